// File: design/necpfd_pkg.sv
`timescale 1ns / 1ps

package necpfd_pkg;

  localparam int MARK_W  = 15;
  localparam int TOL_W   = 12;
  localparam int BYTE_W  = 8;
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  localparam logic [TOL_W-1:0]  RST_TOLERANCE    = 12'd200;
  localparam logic [MARK_W-1:0] RST_LEADER_MARK  = 15'd9000;
  localparam logic [MARK_W-1:0] RST_LEADER_SPACE = 15'd4500;
  localparam logic [MARK_W-1:0] RST_BIT_MARK     = 15'd560;
  localparam logic [MARK_W-1:0] RST_ZERO_SPACE   = 15'd560;
  localparam logic [MARK_W-1:0] RST_ONE_SPACE    = 15'd1690;
  localparam logic [BYTE_W-1:0] RST_MAX_BYTES    = 8'd32;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [2:0] {
    REG_TOLERANCE,
    REG_LEADER_MARK,
    REG_LEADER_SPACE,
    REG_BIT_MARK,
    REG_ZERO_SPACE,
    REG_ONE_SPACE,
    REG_MAX_BYTES
  } reg_idx_t;

  // strict window test, one extra bit so the sums never wrap
  function automatic logic near(input logic [MARK_W-1:0] d,
                                input logic [MARK_W-1:0] nom,
                                input logic [TOL_W-1:0]  tol);
    logic [MARK_W:0] d_x;
    logic [MARK_W:0] nom_x;
    logic [MARK_W:0] tol_x;
    d_x   = {1'b0, d};
    nom_x = {1'b0, nom};
    tol_x = (MARK_W+1)'(tol);
    return (d_x < nom_x + tol_x) && (d_x + tol_x > nom_x);
  endfunction

endpackage

// File: design/necpfd_sym_if.sv
`timescale 1ns / 1ps

interface necpfd_sym_if
  import necpfd_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [MARK_W-1:0] mark_duration;
  logic [MARK_W-1:0] space_duration;
  logic              last_symbol;

  modport source (output valid, mark_duration, space_duration, last_symbol, input ready);
  modport sink   (input valid, mark_duration, space_duration, last_symbol, output ready);
endinterface

// File: design/necpfd_res_if.sv
`timescale 1ns / 1ps

interface necpfd_res_if
  import necpfd_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              result_kind;
  logic [BYTE_W-1:0] data_byte;
  logic              frame_ok;
  logic [BYTE_W-1:0] byte_count;

  modport source (output valid, result_kind, data_byte, frame_ok, byte_count, input ready);
  modport sink   (input valid, result_kind, data_byte, frame_ok, byte_count, output ready);
endinterface

// File: design/nec_pulse_frame_decoder_core.sv
`timescale 1ns / 1ps

// NEC-style infrared frame decoder. Each transfer on in_ch is one symbol (mark and
// space duration in ticks, last_symbol on the ending code); the first symbol of a
// frame is the leader, the rest are data bits packed LSB first. A decoded byte
// leaves on out_ch as soon as its eighth bit arrives while the frame is still valid,
// and the ending code produces a status with frame_ok and the byte count (zero when
// the frame is bad, in which case bytes already sent are to be dropped). Throughput
// is one symbol per clock: the window compares and bit packing sit between the input
// handshake and a single output register, so a result appears in the cycle after its
// symbol and in_ch.ready stays high unless that register holds a result not yet taken.
// Timing registers are written over APB; write them only while no frame is in progress (not enforced).
module nec_pulse_frame_decoder_core
  import necpfd_pkg::*;
#(
  parameter int COUNT_MAX = 255
) (
  input  logic               clk,
  input  logic               rst_n,
  necpfd_sym_if.sink         in_ch,
  necpfd_res_if.source       out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int CAP_MAX = (COUNT_MAX < 255) ? COUNT_MAX : 255;
  localparam int CNT_W   = $clog2(CAP_MAX + 1);

  logic [TOL_W-1:0]  tolerance_r;
  logic [MARK_W-1:0] leader_mark_r;
  logic [MARK_W-1:0] leader_space_r;
  logic [MARK_W-1:0] bit_mark_r;
  logic [MARK_W-1:0] zero_space_r;
  logic [MARK_W-1:0] one_space_r;
  logic [BYTE_W-1:0] max_bytes_r;

  logic              in_data_r, in_data_nxt;
  logic [2:0]        bit_pos_r, bit_pos_nxt;
  logic [BYTE_W-1:0] acc_r, acc_nxt;
  logic              valid_r, valid_nxt;
  logic [CNT_W-1:0]  done_r, done_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              kind_r, kind_nxt;
  logic [BYTE_W-1:0] byte_r, byte_nxt;
  logic              ok_r, ok_nxt;
  logic [BYTE_W-1:0] count_r, count_nxt;

  logic              accept;
  logic              wr_en;
  reg_idx_t          reg_idx;
  logic [BYTE_W-1:0] cap;
  logic              bit_mark_ok;
  logic              is_one;
  logic              is_zero;
  logic              leader_ok;
  logic              end_ok;
  logic [BYTE_W-1:0] acc_set;
  logic              valid_bit;

  // configuration
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tolerance_r    <= RST_TOLERANCE;
      leader_mark_r  <= RST_LEADER_MARK;
      leader_space_r <= RST_LEADER_SPACE;
      bit_mark_r     <= RST_BIT_MARK;
      zero_space_r   <= RST_ZERO_SPACE;
      one_space_r    <= RST_ONE_SPACE;
      max_bytes_r    <= RST_MAX_BYTES;
    end else if (wr_en) begin
      case (reg_idx)
        REG_TOLERANCE:    tolerance_r    <= pwdata[TOL_W-1:0];
        REG_LEADER_MARK:  leader_mark_r  <= pwdata[MARK_W-1:0];
        REG_LEADER_SPACE: leader_space_r <= pwdata[MARK_W-1:0];
        REG_BIT_MARK:     bit_mark_r     <= pwdata[MARK_W-1:0];
        REG_ZERO_SPACE:   zero_space_r   <= pwdata[MARK_W-1:0];
        REG_ONE_SPACE:    one_space_r    <= pwdata[MARK_W-1:0];
        REG_MAX_BYTES:    max_bytes_r    <= pwdata[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TOLERANCE:    prdata = PDATA_W'(tolerance_r);
      REG_LEADER_MARK:  prdata = PDATA_W'(leader_mark_r);
      REG_LEADER_SPACE: prdata = PDATA_W'(leader_space_r);
      REG_BIT_MARK:     prdata = PDATA_W'(bit_mark_r);
      REG_ZERO_SPACE:   prdata = PDATA_W'(zero_space_r);
      REG_ONE_SPACE:    prdata = PDATA_W'(one_space_r);
      REG_MAX_BYTES:    prdata = PDATA_W'(max_bytes_r);
      default:          prdata = '0;
    endcase
  end

  // symbol classification
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign cap = (max_bytes_r < BYTE_W'(CAP_MAX)) ? max_bytes_r : BYTE_W'(CAP_MAX);

  assign bit_mark_ok = near(in_ch.mark_duration, bit_mark_r, tolerance_r);
  assign is_one      = bit_mark_ok && near(in_ch.space_duration, one_space_r, tolerance_r);
  assign is_zero     = bit_mark_ok && near(in_ch.space_duration, zero_space_r, tolerance_r);
  assign leader_ok   = near(in_ch.mark_duration, leader_mark_r, tolerance_r) &&
                       near(in_ch.space_duration, leader_space_r, tolerance_r);
  assign end_ok      = in_data_r && valid_r && (bit_pos_r == 3'd0) && bit_mark_ok;
  assign valid_bit   = valid_r && (is_one || is_zero);

  always_comb begin
    acc_set            = acc_r;
    acc_set[bit_pos_r] = acc_r[bit_pos_r] | is_one;
  end

  always_comb begin
    in_data_nxt   = in_data_r;
    bit_pos_nxt   = bit_pos_r;
    acc_nxt       = acc_r;
    valid_nxt     = valid_r;
    done_nxt      = done_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    kind_nxt      = kind_r;
    byte_nxt      = byte_r;
    ok_nxt        = ok_r;
    count_nxt     = count_r;
    if (accept) begin
      if (in_ch.last_symbol) begin
        out_valid_nxt = 1'b1;
        kind_nxt      = KIND_STATUS;
        byte_nxt      = '0;
        ok_nxt        = end_ok;
        count_nxt     = end_ok ? BYTE_W'(done_r) : '0;
        in_data_nxt   = 1'b0;
        bit_pos_nxt   = 3'd0;
        acc_nxt       = '0;
        valid_nxt     = 1'b1;
        done_nxt      = '0;
      end else if (!in_data_r) begin
        in_data_nxt = 1'b1;
        valid_nxt   = valid_r && leader_ok;
      end else if (BYTE_W'(done_r) < cap) begin
        valid_nxt   = valid_bit;
        bit_pos_nxt = bit_pos_r + 3'd1;
        if (bit_pos_r == 3'd7) begin
          acc_nxt  = '0;
          done_nxt = done_r + CNT_W'(1);
          if (valid_bit) begin
            out_valid_nxt = 1'b1;
            kind_nxt      = KIND_DATA;
            byte_nxt      = acc_set;
            ok_nxt        = 1'b0;
            count_nxt     = '0;
          end
        end else begin
          acc_nxt = acc_set;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_data_r   <= 1'b0;
      bit_pos_r   <= 3'd0;
      acc_r       <= '0;
      valid_r     <= 1'b1;
      done_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      in_data_r   <= in_data_nxt;
      bit_pos_r   <= bit_pos_nxt;
      acc_r       <= acc_nxt;
      valid_r     <= valid_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    byte_r  <= byte_nxt;
    ok_r    <= ok_nxt;
    count_r <= count_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_kind = kind_r;
  assign out_ch.data_byte   = byte_r;
  assign out_ch.frame_ok    = ok_r;
  assign out_ch.byte_count  = count_r;

endmodule

// File: design/necpfd_chk.sv
`timescale 1ns / 1ps

module necpfd_chk
  import necpfd_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              result_kind,
  input logic [BYTE_W-1:0] data_byte,
  input logic              frame_ok,
  input logic [BYTE_W-1:0] byte_count
);

  // result held until transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(data_byte) && $stable(result_kind))
    else $error("result changed before transfer");

  // empty output slot never stalls the input side
  a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (result_kind == KIND_DATA) |-> !frame_ok && (byte_count == '0))
    else $error("data result carries status fields");

  a_bad_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (result_kind == KIND_STATUS) && !frame_ok |->
      (byte_count == '0) && (data_byte == '0))
    else $error("invalid frame reports bytes");

  // a result only follows an input transfer or is still waiting
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid ##1 out_valid |-> $past(in_valid && in_ready))
    else $error("result without input transfer");

endmodule

bind nec_pulse_frame_decoder_core necpfd_chk u_necpfd_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .result_kind(out_ch.result_kind),
  .data_byte  (out_ch.data_byte),
  .frame_ok   (out_ch.frame_ok),
  .byte_count (out_ch.byte_count)
);

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import necpfd_pkg::*;

  localparam int COUNT_LIMIT = 255;
  localparam int CYCLE_LIMIT = 400000;
  localparam int IDLE_PCT    = 38;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] data;
    logic              ok;
    logic [BYTE_W-1:0] count;
  } decoded_t;

  logic               clk;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  necpfd_sym_if sym ();
  necpfd_res_if res ();

  nec_pulse_frame_decoder_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (sym),
    .out_ch  (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // configuration mirror
  int cfg_tol;
  int cfg_leader_mark;
  int cfg_leader_space;
  int cfg_bit_mark;
  int cfg_zero_space;
  int cfg_one_space;
  int cfg_max_bytes;

  // frame decoding state
  bit                in_frame;
  bit                frame_good;
  logic [2:0]        bit_idx;
  logic [BYTE_W-1:0] acc;
  int                bytes_kept;

  decoded_t pending_results[$];

  int  errors;
  int  cycles;
  int  symbols_sent;
  int  bytes_checked;
  int  status_good;
  int  status_bad;
  int  config_phases;
  bit  tx_idle_en;
  bit  rx_idle_en;
  int  hold_req;
  int  hold_left;

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic bit window_hit(input int d, input int nom);
    return (d < nom + cfg_tol) && (d + cfg_tol > nom);
  endfunction

  function automatic void frame_reset();
    in_frame   = 1'b0;
    frame_good = 1'b1;
    bit_idx    = '0;
    acc        = '0;
    bytes_kept = 0;
  endfunction

  function automatic bit decode_symbol(input int m, input int s, input bit last_sym,
                                       output decoded_t r);
    int cap;
    r   = '0;
    cap = (cfg_max_bytes < COUNT_LIMIT) ? cfg_max_bytes : COUNT_LIMIT;
    if (last_sym) begin
      r.kind  = KIND_STATUS;
      r.ok    = in_frame && frame_good && (bit_idx == 0) && window_hit(m, cfg_bit_mark);
      r.count = r.ok ? BYTE_W'(bytes_kept) : '0;
      frame_reset();
      return 1'b1;
    end
    if (!in_frame) begin
      in_frame = 1'b1;
      if (!(window_hit(m, cfg_leader_mark) && window_hit(s, cfg_leader_space)))
        frame_good = 1'b0;
      return 1'b0;
    end
    if (bytes_kept >= cap)
      return 1'b0;
    if (window_hit(m, cfg_bit_mark) && window_hit(s, cfg_one_space))
      acc[bit_idx] = 1'b1;
    else if (!(window_hit(m, cfg_bit_mark) && window_hit(s, cfg_zero_space)))
      frame_good = 1'b0;
    bit_idx = bit_idx + 3'd1;
    if (bit_idx != 0)
      return 1'b0;
    r.kind = KIND_DATA;
    r.data = acc;
    acc    = '0;
    bytes_kept++;
    return frame_good;
  endfunction

  function automatic logic [MARK_W-1:0] clamp_dur(input int v);
    if (v < 0)
      return '0;
    if (v > 32767)
      return '1;
    return MARK_W'(v);
  endfunction

  function automatic logic [MARK_W-1:0] dur_near(input int nom);
    int t;
    t = cfg_tol;
    if (t <= 1)
      return clamp_dur(nom);
    return clamp_dur(nom + int'($urandom_range(2 * t - 2)) - (t - 1));
  endfunction

  function automatic logic [MARK_W-1:0] dur_boundary(input int nom);
    case ($urandom_range(3))
      0: return clamp_dur(nom - cfg_tol);
      1: return clamp_dur(nom + cfg_tol);
      2: return clamp_dur(nom - cfg_tol + 1);
      default: return clamp_dur(nom + cfg_tol - 1);
    endcase
  endfunction

  function automatic logic [MARK_W-1:0] dur_noise();
    return MARK_W'($urandom_range(32767));
  endfunction

  // receiver side
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      res.ready <= 1'b0;
    end else begin
      res.ready <= rx_idle_en ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    decoded_t want;
    if (rst_n && res.valid && res.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0b byte %02h ok %0b count %0d",
                                  res.result_kind, res.data_byte, res.frame_ok,
                                  res.byte_count));
      end else begin
        want = pending_results.pop_front();
        if (res.result_kind !== want.kind)
          report_mismatch($sformatf("result_kind %0b, want %0b", res.result_kind, want.kind));
        if (res.data_byte !== want.data)
          report_mismatch($sformatf("data_byte %02h, want %02h", res.data_byte, want.data));
        if (res.frame_ok !== want.ok)
          report_mismatch($sformatf("frame_ok %0b, want %0b", res.frame_ok, want.ok));
        if (res.byte_count !== want.count)
          report_mismatch($sformatf("byte_count %0d, want %0d", res.byte_count, want.count));
        if (want.kind == KIND_DATA)
          bytes_checked++;
        else if (want.ok)
          status_good++;
        else
          status_bad++;
      end
    end
  end

  task automatic send_symbol(input logic [MARK_W-1:0] m, input logic [MARK_W-1:0] s,
                             input bit last_sym);
    decoded_t r;
    while (tx_idle_en && $urandom_range(99) < IDLE_PCT) begin
      @(negedge clk);
      sym.valid <= 1'b0;
    end
    @(negedge clk);
    sym.valid          <= 1'b1;
    sym.mark_duration  <= m;
    sym.space_duration <= s;
    sym.last_symbol    <= last_sym;
    do @(posedge clk); while (!sym.ready);
    symbols_sent++;
    if (decode_symbol(int'(m), int'(s), last_sym, r))
      pending_results.push_back(r);
  endtask

  task automatic wait_results_done();
    @(negedge clk);
    sym.valid <= 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input int value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * int'(idx));
    pwdata  <= PDATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_TOLERANCE:    cfg_tol          = value & 'hFFF;
      REG_LEADER_MARK:  cfg_leader_mark  = value & 'h7FFF;
      REG_LEADER_SPACE: cfg_leader_space = value & 'h7FFF;
      REG_BIT_MARK:     cfg_bit_mark     = value & 'h7FFF;
      REG_ZERO_SPACE:   cfg_zero_space   = value & 'h7FFF;
      REG_ONE_SPACE:    cfg_one_space    = value & 'h7FFF;
      REG_MAX_BYTES:    cfg_max_bytes    = value & 'hFF;
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_config(input int tol, input int lm, input int ls, input int bm,
                              input int zs, input int os, input int mb);
    wait_results_done();
    write_reg(REG_TOLERANCE, tol);
    write_reg(REG_LEADER_MARK, lm);
    write_reg(REG_LEADER_SPACE, ls);
    write_reg(REG_BIT_MARK, bm);
    write_reg(REG_ZERO_SPACE, zs);
    write_reg(REG_ONE_SPACE, os);
    write_reg(REG_MAX_BYTES, mb);
    config_phases++;
  endtask

  task automatic send_frame(input int nbits, input bit clean);
    int                r;
    bit                one;
    logic [MARK_W-1:0] m;
    logic [MARK_W-1:0] s;
    r = clean ? 0 : $urandom_range(99);
    if (r < 90)
      send_symbol(dur_near(cfg_leader_mark), dur_near(cfg_leader_space), 1'b0);
    else if (r < 95)
      send_symbol(dur_boundary(cfg_leader_mark), dur_near(cfg_leader_space), 1'b0);
    else
      send_symbol(dur_noise(), dur_noise(), 1'b0);
    for (int i = 0; i < nbits; i++) begin
      if (!clean && $urandom_range(99) < 2)
        wait_results_done();
      r   = clean ? 0 : $urandom_range(99);
      one = $urandom_range(1);
      m   = dur_near(cfg_bit_mark);
      s   = dur_near(one ? cfg_one_space : cfg_zero_space);
      if (r >= 96) begin
        m = dur_noise();
        s = dur_noise();
      end else if (r >= 94) begin
        m = dur_boundary(cfg_bit_mark);
      end else if (r >= 92) begin
        s = dur_boundary(one ? cfg_one_space : cfg_zero_space);
      end
      send_symbol(m, s, 1'b0);
    end
    r = clean ? 0 : $urandom_range(99);
    if (r < 85)
      send_symbol(dur_near(cfg_bit_mark), dur_noise(), 1'b1);
    else if (r < 93)
      send_symbol(dur_boundary(cfg_bit_mark), dur_noise(), 1'b1);
    else
      send_symbol(dur_noise(), dur_noise(), 1'b1);
  endtask

  task automatic send_random_frame();
    int r;
    int nbits;
    r = $urandom_range(99);
    if (r < 75)
      nbits = 8 * $urandom_range(4);
    else if (r < 85)
      nbits = $urandom_range(1, 20);
    else
      nbits = 8 * $urandom_range(5, 8);
    send_frame(nbits, 1'b0);
  endtask

  // runs on reset values of the registers
  task automatic test_directed_edges();
    // lone ending code with extreme durations
    send_symbol(15'h7FFF, 15'h7FFF, 1'b1);
    // all-ones byte at the inner edges of the windows
    send_symbol(15'd9000, 15'd4500, 1'b0);
    repeat (8) send_symbol(15'd759, 15'd1491, 1'b0);
    send_symbol(15'd361, 15'd0, 1'b1);
    // bad leader, zero bits still counted
    send_symbol(15'd0, 15'd0, 1'b0);
    repeat (8) send_symbol(15'd560, 15'd560, 1'b0);
    send_symbol(15'd560, 15'h7FFF, 1'b1);
    // ending mark just outside its window
    send_symbol(15'd9000, 15'd4500, 1'b0);
    send_symbol(15'd760, 15'h2AAA, 1'b1);
  endtask

  task automatic test_register_sweep();
    int base;
    for (int p = 0; p < 9; p++) begin
      case (p)
        0: apply_config(200, 9000, 4500, 560, 560, 1690, 32);
        1: apply_config(4095, 9000, 4500, 560, 560, 1690, 32);
        2: apply_config(0, 9000, 4500, 560, 560, 1690, 32);
        3: apply_config(1, 9000, 4500, 560, 560, 1690, 1);
        4: apply_config(100, 32767, 0, 0, 0, 32767, 255);
        5: apply_config(150, 9000, 4500, 560, 1000, 1000, 3);
        8: apply_config(200, 9000, 4500, 560, 560, 1690, 2);
        default: apply_config($urandom_range(1, 600), $urandom_range(32767),
                              $urandom_range(32767), $urandom_range(32767),
                              $urandom_range(32767), $urandom_range(32767),
                              $urandom_range(1, 6));
      endcase
      base = symbols_sent;
      while (symbols_sent - base < 120)
        send_random_frame();
    end
  endtask

  task automatic test_full_rate();
    int base;
    apply_config(200, 9000, 4500, 560, 560, 1690, 4);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    base = symbols_sent;
    while (symbols_sent - base < 150)
      send_random_frame();
    wait_results_done();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  task automatic test_output_stall();
    apply_config(200, 9000, 4500, 560, 560, 1690, 32);
    tx_idle_en = 1'b0;
    @(posedge clk);
    hold_req = 300;
    send_frame(48, 1'b1);
    wait_results_done();
    tx_idle_en = 1'b1;
  endtask

  task automatic test_noise();
    repeat (60)
      send_symbol(dur_noise(), dur_noise(), $urandom_range(99) < 25);
    send_symbol(dur_noise(), dur_noise(), 1'b1);
  endtask

  initial begin
    clk                = 1'b0;
    rst_n              = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    sym.valid          = 1'b0;
    sym.mark_duration  = '0;
    sym.space_duration = '0;
    sym.last_symbol    = 1'b0;
    res.ready          = 1'b0;
    errors             = 0;
    cycles             = 0;
    symbols_sent       = 0;
    bytes_checked      = 0;
    status_good        = 0;
    status_bad         = 0;
    config_phases      = 0;
    tx_idle_en         = 1'b1;
    rx_idle_en         = 1'b1;
    hold_req           = 0;
    hold_left          = 0;
    cfg_tol            = int'(RST_TOLERANCE);
    cfg_leader_mark    = int'(RST_LEADER_MARK);
    cfg_leader_space   = int'(RST_LEADER_SPACE);
    cfg_bit_mark       = int'(RST_BIT_MARK);
    cfg_zero_space     = int'(RST_ZERO_SPACE);
    cfg_one_space      = int'(RST_ONE_SPACE);
    cfg_max_bytes      = int'(RST_MAX_BYTES);
    frame_reset();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_edges();
    test_register_sweep();
    test_full_rate();
    test_output_stall();
    test_noise();

    wait_results_done();
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

    $display("sent %0d symbols across %0d register settings, with stalls on both sides",
             symbols_sent, config_phases);
    $display("checked %0d data bytes and %0d frame statuses (%0d good, %0d rejected)",
             bytes_checked, status_good + status_bad, status_good, status_bad);
    if (errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
